@@ sv/mm_pkg.sv @@
`timescale 1ns / 1ps

package mm_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_INNER = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  // Command kinds held in the queue
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic [3:0] rows;
    logic [3:0] inner;
    logic [3:0] cols;
  } dims_t;

endpackage

@@ sv/matrix_multiply.sv @@
`timescale 1ns / 1ps
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | operation, row_index, col_index, element_value
// out     | out_valid / out_ready | out_row, out_col, product_value, last
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A load is written to its store as the back end pops it; the front accepts one request a cycle
// while the four-entry queue has room. A compute produces nr*nc elements:
// each element walks nk reads of the A and B stores (one read port each), then a
// multiply, accumulate and saturate stage, one element at a time.
// Reset is synchronous; store contents are undefined until written.
// A stalled output holds the element walk; the queue keeps taking requests until
// full, and requests behind a compute wait until its last element is delivered.
module matrix_multiply #(
  parameter int MAX_DIM = 8,
  parameter int FRAC_BITS = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [2:0]         row_index,
  input  logic [2:0]         col_index,
  input  logic signed [31:0] element_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [31:0] product_value,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  mm_pkg::dims_t dims;
  mm_pkg::cmd_t push_cmd, head;
  logic push, pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.rows <= 4'd8;
      dims.inner <= 4'd8;
      dims.cols <= 4'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mm_pkg::REG_ROWS: dims.rows <= cfg_data;
        mm_pkg::REG_INNER: dims.inner <= cfg_data;
        mm_pkg::REG_COLS: dims.cols <= cfg_data;
        default: ;
      endcase
    end
  end

  mm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .in_valid(in_valid), .operation(operation), .row_index(row_index),
    .col_index(col_index), .element_value(element_value), .q_full(q_full),
    .in_ready(in_ready), .push(push), .push_cmd(push_cmd)
  );

  mm_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .pop(pop),
    .full(q_full), .empty(q_empty), .head(head)
  );

  mm_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .head(head), .dims(dims), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_row(out_row),
    .out_col(out_col), .product_value(product_value), .last(last)
  );

endmodule

@@ sv/mm_ram.sv @@
`timescale 1ns / 1ps

module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/mm_front.sv @@
`timescale 1ns / 1ps

module mm_front #(
  parameter int MAX_DIM = 8
) (
  input  logic            in_valid,
  input  logic [1:0]      operation,
  input  logic [2:0]      row_index,
  input  logic [2:0]      col_index,
  input  logic [31:0]     element_value,
  input  logic            q_full,
  output logic            in_ready,
  output logic            push,
  output mm_pkg::cmd_t    push_cmd
);

  logic in_range;
  logic legal;

  assign in_range = ({1'b0, row_index} < 4'(MAX_DIM)) && ({1'b0, col_index} < 4'(MAX_DIM));
  assign in_ready = !q_full;

  // Drop unknown operations and loads outside the store
  always_comb begin
    legal = 1'b0;
    push_cmd.kind = mm_pkg::CMD_COMPUTE;
    push_cmd.row = row_index;
    push_cmd.col = col_index;
    push_cmd.data = element_value;
    unique case (operation)
      mm_pkg::OP_LOAD_A: begin
        legal = in_range;
        push_cmd.kind = mm_pkg::CMD_LOAD_A;
      end
      mm_pkg::OP_LOAD_B: begin
        legal = in_range;
        push_cmd.kind = mm_pkg::CMD_LOAD_B;
      end
      mm_pkg::OP_COMPUTE: begin
        legal = 1'b1;
      end
      default: legal = 1'b0;
    endcase
  end

  assign push = in_valid && !q_full && legal;

endmodule

@@ sv/mm_queue.sv @@
`timescale 1ns / 1ps

module mm_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  mm_pkg::cmd_t push_cmd,
  input  logic         pop,
  output logic         full,
  output logic         empty,
  output mm_pkg::cmd_t head
);

  mm_pkg::cmd_t entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

@@ sv/mm_back.sv @@
`timescale 1ns / 1ps

module mm_back #(
  parameter int MAX_DIM = 8,
  parameter int FRAC_BITS = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  mm_pkg::cmd_t        head,
  input  mm_pkg::dims_t       dims,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_row,
  output logic [2:0]          out_col,
  output logic signed [31:0]  product_value,
  output logic                last
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(DEPTH);
  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;
  localparam int ACCW = PW + 3;
  localparam logic signed [ACCW-1:0] SAT_MAX = {{(ACCW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACCW-1:0] SAT_MIN = {{(ACCW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN = 1'b1;

  function automatic logic [IW-1:0] last_index(input logic [3:0] v);
    if (v == 4'd0) return '0;
    else if (v > 4'(MAX_DIM)) return IW'(MAX_DIM - 1);
    else return IW'(v - 4'd1);
  endfunction

  logic state;
  logic [IW-1:0] nr_last, nk_last, nc_last;
  logic [IW-1:0] i, j, k;
  logic [IW-1:0] elem_row, elem_col;
  logic elem_final, elem_busy, issuing;
  logic rv, rfirst, rlast;
  logic mv, mfirst, mlast;
  logic sum_v;
  logic signed [PW-1:0] prod;
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] shifted;
  logic signed [DW-1:0] sat_res;
  logic [DW-1:0] a_data, b_data;
  logic wr_a, wr_b;
  logic [AW-1:0] wr_addr, a_raddr, b_raddr;
  logic start, take;

  // Hold the queue until the last element of a compute has been delivered
  assign pop = (state == S_IDLE) && !elem_busy && !q_empty;
  assign wr_a = pop && (head.kind == mm_pkg::CMD_LOAD_A);
  assign wr_b = pop && (head.kind == mm_pkg::CMD_LOAD_B);
  assign wr_addr = AW'(int'(head.row) * MAX_DIM + int'(head.col));
  assign a_raddr = AW'(int'(elem_row) * MAX_DIM + int'(k));
  assign b_raddr = AW'(int'(k) * MAX_DIM + int'(elem_col));

  mm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_a_ram (
    .clk(clk), .wr_en(wr_a), .wr_addr(wr_addr), .wr_data(head.data[DW-1:0]),
    .rd_addr(a_raddr), .rd_data(a_data)
  );

  mm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_b_ram (
    .clk(clk), .wr_en(wr_b), .wr_addr(wr_addr), .wr_data(head.data[DW-1:0]),
    .rd_addr(b_raddr), .rd_data(b_data)
  );

  assign start = (state == S_RUN) && !elem_busy;
  assign take = sum_v && (!out_valid || out_ready);

  // Floor shift, then clamp to the signed data range
  assign shifted = acc >>> FRAC_BITS;
  always_comb begin
    priority if (shifted > SAT_MAX) sat_res = SAT_MAX[DW-1:0];
    else if (shifted < SAT_MIN) sat_res = SAT_MIN[DW-1:0];
    else sat_res = shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      elem_busy <= 1'b0;
      issuing <= 1'b0;
      rv <= 1'b0;
      mv <= 1'b0;
      sum_v <= 1'b0;
      out_valid <= 1'b0;
      nr_last <= '0;
      nk_last <= '0;
      nc_last <= '0;
      i <= '0;
      j <= '0;
      k <= '0;
    end else begin
      if (pop && head.kind == mm_pkg::CMD_COMPUTE) begin
        state <= S_RUN;
        nr_last <= last_index(dims.rows);
        nk_last <= last_index(dims.inner);
        nc_last <= last_index(dims.cols);
        i <= '0;
        j <= '0;
      end
      if (start) begin
        elem_busy <= 1'b1;
        issuing <= 1'b1;
        k <= '0;
        if (j == nc_last) begin
          j <= '0;
          i <= i + 1'b1;
          if (i == nr_last) state <= S_IDLE;
        end else begin
          j <= j + 1'b1;
        end
      end
      if (issuing) begin
        if (k == nk_last) issuing <= 1'b0;
        else k <= k + 1'b1;
      end
      rv <= issuing;
      mv <= rv;
      if (mv && mlast) sum_v <= 1'b1;
      else if (take) sum_v <= 1'b0;
      if (take) begin
        elem_busy <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      elem_row <= i;
      elem_col <= j;
      elem_final <= (i == nr_last) && (j == nc_last);
    end
    rfirst <= (k == '0);
    rlast <= (k == nk_last);
    mfirst <= rfirst;
    mlast <= rlast;
    prod <= signed'(a_data) * signed'(b_data);
    if (mv) begin
      acc <= mfirst ? ACCW'(prod) : acc + ACCW'(prod);
    end
    if (take) begin
      out_row <= 3'(elem_row);
      out_col <= 3'(elem_col);
      product_value <= 32'(sat_res);
      last <= elem_final;
    end
  end

  a_single_elem: assert property (@(posedge clk) disable iff (rst) sum_v |-> !mv && !issuing)
    else $error("second element entered the datapath");
  a_issue_busy: assert property (@(posedge clk) disable iff (rst) issuing |-> elem_busy)
    else $error("reads issued without an element in flight");
  a_load_idle: assert property (@(posedge clk) disable iff (rst) (wr_a || wr_b) |-> !issuing)
    else $error("store written while reads are issued");
  a_busy_clear: assert property (@(posedge clk) disable iff (rst) take |=> !elem_busy || start)
    else $error("element stayed busy after delivery");

endmodule

@@ test/matrix_multiply_tb.sv @@
`timescale 1ns / 1ps

module matrix_multiply_tb;

  typedef struct {
    logic [1:0]         op;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } mm_req_t;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic               last;
  } prod_elem_t;

  localparam logic [1:0] OP_NONE = 2'd3;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         operation;
  logic [2:0]         row_index;
  logic [2:0]         col_index;
  logic signed [31:0] element_value;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_row;
  logic [2:0]         out_col;
  logic signed [31:0] product_value;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [3:0]         cfg_data;

  matrix_multiply u_dut (.*);

  mm_req_t            req_queue[$];
  prod_elem_t         product_queue[$];
  logic signed [31:0] a_mem[64];
  logic signed [31:0] b_mem[64];
  logic [3:0]         dims_reg[3];
  bit                 a_loaded[64];
  bit                 b_loaded[64];
  bit                 in_taken;
  bit                 idle_on;
  int                 in_gap;
  int                 out_gap;
  int                 errors;
  int                 n_requests;
  int                 n_products;
  int                 n_computes;
  int                 n_pushed;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("timeout at %0t", $time);
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_dim(logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  function automatic logic signed [31:0] dot_product(int r, int c, int nk);
    logic signed [79:0] acc;
    logic signed [63:0] p;
    logic signed [79:0] shifted;
    acc = '0;
    for (int k = 0; k < nk; k++) begin
      p = a_mem[r * 8 + k] * b_mem[k * 8 + c];
      acc = acc + p;
    end
    shifted = acc >>> 16;
    if (shifted > 80'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (shifted < -80'sh8000_0000) return 32'sh8000_0000;
    return shifted[31:0];
  endfunction

  task automatic predict_request(mm_req_t q);
    prod_elem_t e;
    int nr, nk, nc;
    n_requests++;
    case (q.op)
      mm_pkg::OP_LOAD_A: a_mem[q.row * 8 + q.col] = q.value;
      mm_pkg::OP_LOAD_B: b_mem[q.row * 8 + q.col] = q.value;
      mm_pkg::OP_COMPUTE: begin
        nr = eff_dim(dims_reg[mm_pkg::REG_ROWS]);
        nk = eff_dim(dims_reg[mm_pkg::REG_INNER]);
        nc = eff_dim(dims_reg[mm_pkg::REG_COLS]);
        n_computes++;
        for (int i = 0; i < nr; i++)
          for (int j = 0; j < nc; j++) begin
            e.row = 3'(i);
            e.col = 3'(j);
            e.value = dot_product(i, j, nk);
            e.last = (i == nr - 1) && (j == nc - 1);
            product_queue.push_back(e);
          end
      end
      default: ;
    endcase
  endtask

  // Request side
  always @(posedge clk) begin
    mm_req_t q;
    if (!rst && in_valid && in_ready) begin
      q.op = operation;
      q.row = row_index;
      q.col = col_index;
      q.value = element_value;
      predict_request(q);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    mm_req_t q;
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (req_queue.size() > 0) begin
        q = req_queue.pop_front();
        operation <= q.op;
        row_index <= q.row;
        col_index <= q.col;
        element_value <= q.value;
        in_valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side
  always @(negedge clk) begin
    if (!rst) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    prod_elem_t e;
    if (!rst && out_valid && out_ready) begin
      n_products++;
      if (product_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected product row %0d col %0d value %h last %b",
                 $time, out_row, out_col, product_value, last);
      end else begin
        e = product_queue.pop_front();
        if (out_row !== e.row) begin
          errors++;
          $display("%0t: out_row expected %0d actual %0d", $time, e.row, out_row);
        end
        if (out_col !== e.col) begin
          errors++;
          $display("%0t: out_col expected %0d actual %0d", $time, e.col, out_col);
        end
        if (product_value !== e.value) begin
          errors++;
          $display("%0t: product_value (%0d,%0d) expected %h actual %h",
                   $time, e.row, e.col, e.value, product_value);
        end
        if (last !== e.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, e.last, last);
        end
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return $urandom();
      4: return -32'sd1;
      default: return $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
    endcase
  endfunction

  task automatic push_req(logic [1:0] op, int r, int c, logic signed [31:0] v);
    mm_req_t q;
    q.op = op;
    q.row = 3'(r);
    q.col = 3'(c);
    q.value = v;
    req_queue.push_back(q);
    n_pushed++;
    if (op == mm_pkg::OP_LOAD_A) a_loaded[r * 8 + c] = 1'b1;
    if (op == mm_pkg::OP_LOAD_B) b_loaded[r * 8 + c] = 1'b1;
  endtask

  // Fill any operand entry the walk would read before it was ever loaded
  task automatic push_compute();
    int nr, nk, nc;
    nr = eff_dim(dims_reg[mm_pkg::REG_ROWS]);
    nk = eff_dim(dims_reg[mm_pkg::REG_INNER]);
    nc = eff_dim(dims_reg[mm_pkg::REG_COLS]);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_loaded[i * 8 + k]) push_req(mm_pkg::OP_LOAD_A, i, k, pick_value());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_loaded[k * 8 + j]) push_req(mm_pkg::OP_LOAD_B, k, j, pick_value());
    push_req(mm_pkg::OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
  endtask

  task automatic drain();
    while (req_queue.size() > 0 || in_valid || product_queue.size() > 0)
      @(posedge clk);
    // loads may still sit in the block's queue
    repeat (20) @(posedge clk);
  endtask

  task automatic write_dim(logic [1:0] idx, logic [3:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    dims_reg[idx] = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      3: return 4'd1;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = mm_pkg::OP_LOAD_A;
    row_index = '0;
    col_index = '0;
    element_value = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = mm_pkg::REG_ROWS;
    cfg_data = '0;
    dims_reg[mm_pkg::REG_ROWS] = 4'd8;
    dims_reg[mm_pkg::REG_INNER] = 4'd8;
    dims_reg[mm_pkg::REG_COLS] = 4'd8;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: saturation both ways, floor rounding, unknown operation
    write_dim(mm_pkg::REG_ROWS, 4'd1);
    write_dim(mm_pkg::REG_INNER, 4'd2);
    write_dim(mm_pkg::REG_COLS, 4'd1);
    push_req(mm_pkg::OP_LOAD_A, 0, 0, 32'sh7FFF_FFFF);
    push_req(mm_pkg::OP_LOAD_A, 0, 1, 32'sh7FFF_FFFF);
    push_req(mm_pkg::OP_LOAD_B, 0, 0, 32'sh7FFF_FFFF);
    push_req(mm_pkg::OP_LOAD_B, 1, 0, 32'sh7FFF_FFFF);
    push_req(mm_pkg::OP_COMPUTE, 7, 7, 32'sh8000_0000);
    push_req(mm_pkg::OP_LOAD_B, 0, 0, 32'sh8000_0000);
    push_req(mm_pkg::OP_LOAD_B, 1, 0, 32'sh8000_0000);
    push_req(mm_pkg::OP_COMPUTE, 0, 0, 32'sd0);
    push_req(OP_NONE, 7, 7, 32'shFFFF_FFFF);
    push_req(mm_pkg::OP_LOAD_A, 0, 0, -32'sd1);
    push_req(mm_pkg::OP_LOAD_A, 0, 1, 32'sd1);
    push_req(mm_pkg::OP_LOAD_B, 0, 0, 32'sd1);
    push_req(mm_pkg::OP_LOAD_B, 1, 0, 32'sd0);
    push_req(mm_pkg::OP_COMPUTE, 0, 0, 32'sd0);
    push_req(mm_pkg::OP_LOAD_A, 7, 7, 32'sh5555_AAAA);
    push_req(mm_pkg::OP_LOAD_B, 7, 7, 32'shAAAA_5555);
    push_req(mm_pkg::OP_LOAD_B, 3, 5, 32'sh0001_0000);
    drain();

    // Random phases with the sender held until each drains
    while (n_pushed < 330) begin
      idle_on = $urandom_range(0, 3) != 0;
      write_dim(mm_pkg::REG_ROWS, pick_dim());
      write_dim(mm_pkg::REG_INNER, pick_dim());
      write_dim(mm_pkg::REG_COLS, pick_dim());
      repeat ($urandom_range(20, 45)) begin
        case ($urandom_range(0, 19))
          0, 1: push_compute();
          2: push_req(OP_NONE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
          default: push_req($urandom_range(0, 1) ? mm_pkg::OP_LOAD_A : mm_pkg::OP_LOAD_B,
                            $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
        endcase
      end
      push_compute();
      drain();
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d requests with %0d computes, %0d product elements checked",
             n_requests, n_computes, n_products);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
